/* rtl/brsts_pkg.sv */
`default_nettype none

package brsts_pkg;

   // Fixed field widths of the words.
   localparam int KEY_W = 10;
   localparam int BIT_CNT_W = $clog2(KEY_W + 1);

   // Defaults for the top-level parameters.
   localparam int MAX_ITEMS_DEFAULT = 64;
   localparam int KEY_BITS_DEFAULT = 10;

   // Input word.
   typedef struct packed {
      logic [KEY_W-1:0] key_value;
      logic             last_item;
   } req_word_type;

   // Result word.
   typedef struct packed {
      logic [KEY_W-1:0] sorted_value;
      logic             last_out;
      logic             overflow;
   } rsp_word_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic prep;
      logic left_load;
      logic scan_issue;
      logic pop_issue;
      logic emit_issue;
      logic bit_next;
      logic clear;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic left_nz;
      logic aux_nz;
      logic pipe_busy;
      logic sort_needed;
      logic last_pass;
   } status_type;

   // Number of significant bits in a key, zero for a zero key.
   function automatic logic [BIT_CNT_W-1:0] bit_length(input logic [KEY_W-1:0] v);
      logic [BIT_CNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < KEY_W; i++) begin
         if (v[i]) begin
            n = BIT_CNT_W'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

`default_nettype wire

/* rtl/brsts_ram.sv */
`default_nettype none

module brsts_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/brsts_ctrl.sv */
`default_nettype none

module brsts_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic                   req_last,
   input  wire brsts_pkg::status_type  status,
   output brsts_pkg::cmd_type          cmd,
   output logic                        busy
);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PREP,
      ST_SCAN,
      ST_POP,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   // Next state and the commands of this cycle.
   always_comb begin
      state_in = state_ff;
      busy_in  = busy_ff;
      cmd      = '0;
      case (state_ff)
         ST_LOAD: begin
            if (start) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  busy_in  = 1'b1;
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            cmd.prep      = 1'b1;
            cmd.left_load = 1'b1;
            state_in      = status.sort_needed ? ST_SCAN : ST_EMIT;
         end
         ST_SCAN: begin
            if (status.left_nz) begin
               cmd.scan_issue = 1'b1;
            end else if (!status.pipe_busy) begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            if (status.aux_nz) begin
               cmd.pop_issue = 1'b1;
            end else if (!status.pipe_busy) begin
               cmd.left_load = 1'b1;
               if (status.last_pass) begin
                  state_in = ST_EMIT;
               end else begin
                  cmd.bit_next = 1'b1;
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_EMIT: begin
            if (status.left_nz) begin
               cmd.emit_issue = 1'b1;
            end else if (!status.pipe_busy) begin
               cmd.clear = 1'b1;
               busy_in   = 1'b0;
               state_in  = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
            busy_in  = 1'b0;
         end
      endcase
   end

   // State and the registered busy flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

/* rtl/brsts_dpath.sv */
`default_nettype none

module brsts_dpath #(
   parameter int MAX_ITEMS = brsts_pkg::MAX_ITEMS_DEFAULT,
   parameter int KEY_BITS  = brsts_pkg::KEY_BITS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [brsts_pkg::KEY_W-1:0] key_value,
   input  wire brsts_pkg::cmd_type          cmd,
   output brsts_pkg::status_type            status,
   output logic                             rsp_strobe,
   output brsts_pkg::rsp_word_type          rsp_word
);

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int KW = brsts_pkg::KEY_W;
   localparam int BW = brsts_pkg::BIT_CNT_W;
   localparam logic [AW-1:0] LastSlot = AW'(MAX_ITEMS - 1);
   localparam logic [CW-1:0] MaxCount = CW'(MAX_ITEMS);
   localparam logic [KW-1:0] KeyMask =
      (KEY_BITS >= KW) ? {KW{1'b1}} : KW'((64'd1 << KEY_BITS) - 64'd1);

   typedef enum logic [1:0] {
      TAG_NONE,
      TAG_SCAN,
      TAG_POP,
      TAG_EMIT
   } tag_type;

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] aux_ptr_ff, aux_ptr_in;
   logic [CW-1:0] left_ff, left_in;
   logic [KW-1:0] largest_ff, largest_in;
   logic          dropped_ff, dropped_in;
   logic [BW-1:0] bit_ff, bit_in;
   logic [BW-1:0] nbits_ff, nbits_in;
   tag_type       tag_ff, tag_in;
   logic          emit_last_ff, emit_last_in;

   logic [KW-1:0] key_masked;
   logic [KW-1:0] deque_q, aux_q;
   logic          deque_we, aux_we;
   logic [AW-1:0] deque_waddr, aux_waddr, aux_raddr;
   logic [KW-1:0] deque_wdata;
   logic [AW-1:0] head_inc, head_dec, tail_inc;
   logic          load_ok, scan_proc, pop_proc, scan_bit;

   assign key_masked = key_value & KeyMask;

   // Circular slot arithmetic, also for a depth that is not a power of two.
   assign head_inc = (head_ff == LastSlot) ? '0 : head_ff + AW'(1);
   assign head_dec = (head_ff == '0) ? LastSlot : head_ff - AW'(1);
   assign tail_inc = (tail_ff == LastSlot) ? '0 : tail_ff + AW'(1);

   assign load_ok   = cmd.load && (count_ff != MaxCount);
   assign scan_proc = (tag_ff == TAG_SCAN);
   assign pop_proc  = (tag_ff == TAG_POP);
   assign scan_bit  = deque_q[bit_ff];

   // Deque write port: loaded keys and keys with the bit set go to the back,
   // popped keys go to the front.
   always_comb begin
      deque_we    = 1'b0;
      deque_waddr = tail_ff;
      deque_wdata = key_masked;
      if (load_ok) begin
         deque_we = 1'b1;
      end else if (scan_proc && scan_bit) begin
         deque_we    = 1'b1;
         deque_wdata = deque_q;
      end else if (pop_proc) begin
         deque_we    = 1'b1;
         deque_waddr = head_dec;
         deque_wdata = aux_q;
      end
   end

   // Keys with the bit clear are pushed onto the auxiliary stack.
   assign aux_we    = scan_proc && !scan_bit;
   assign aux_waddr = AW'(aux_ptr_ff);
   assign aux_raddr = AW'(aux_ptr_ff - CW'(1));

   brsts_ram #(
      .WIDTH (KW),
      .DEPTH (MAX_ITEMS)
   ) u_deque_ram (
      .clock   (clock),
      .wr_en   (deque_we),
      .wr_addr (deque_waddr),
      .wr_data (deque_wdata),
      .rd_addr (head_ff),
      .rd_data (deque_q)
   );

   brsts_ram #(
      .WIDTH (KW),
      .DEPTH (MAX_ITEMS)
   ) u_aux_ram (
      .clock   (clock),
      .wr_en   (aux_we),
      .wr_addr (aux_waddr),
      .wr_data (deque_q),
      .rd_addr (aux_raddr),
      .rd_data (aux_q)
   );

   // Next values of pointers, counters and flags.
   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      aux_ptr_in   = aux_ptr_ff;
      left_in      = left_ff;
      largest_in   = largest_ff;
      dropped_in   = dropped_ff;
      bit_in       = bit_ff;
      nbits_in     = nbits_ff;
      tag_in       = TAG_NONE;
      emit_last_in = 1'b0;

      if (cmd.load) begin
         if (load_ok) begin
            count_in = count_ff + CW'(1);
            if (key_masked > largest_ff) begin
               largest_in = key_masked;
            end
         end else begin
            dropped_in = 1'b1;
         end
      end
      if (load_ok || (scan_proc && scan_bit)) begin
         tail_in = tail_inc;
      end
      if (aux_we) begin
         aux_ptr_in = aux_ptr_ff + CW'(1);
      end
      if (pop_proc) begin
         head_in = head_dec;
      end
      if (cmd.scan_issue || cmd.emit_issue) begin
         head_in = head_inc;
         left_in = left_ff - CW'(1);
      end
      if (cmd.pop_issue) begin
         aux_ptr_in = aux_ptr_ff - CW'(1);
      end
      if (cmd.left_load) begin
         left_in = count_ff;
      end
      if (cmd.prep) begin
         bit_in   = '0;
         nbits_in = brsts_pkg::bit_length(largest_ff);
      end
      if (cmd.bit_next) begin
         bit_in = bit_ff + BW'(1);
      end

      // Tag of the read now in flight through the RAMs.
      if (cmd.scan_issue) begin
         tag_in = TAG_SCAN;
      end else if (cmd.pop_issue) begin
         tag_in = TAG_POP;
      end else if (cmd.emit_issue) begin
         tag_in       = TAG_EMIT;
         emit_last_in = (left_ff == CW'(1));
      end

      if (cmd.clear) begin
         head_in    = '0;
         tail_in    = '0;
         count_in   = '0;
         aux_ptr_in = '0;
         largest_in = '0;
         dropped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         aux_ptr_ff   <= '0;
         left_ff      <= '0;
         largest_ff   <= '0;
         dropped_ff   <= 1'b0;
         bit_ff       <= '0;
         nbits_ff     <= '0;
         tag_ff       <= TAG_NONE;
         emit_last_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         aux_ptr_ff   <= aux_ptr_in;
         left_ff      <= left_in;
         largest_ff   <= largest_in;
         dropped_ff   <= dropped_in;
         bit_ff       <= bit_in;
         nbits_ff     <= nbits_in;
         tag_ff       <= tag_in;
         emit_last_ff <= emit_last_in;
      end
   end

   // Status for the controller.
   always_comb begin
      status.left_nz     = (left_ff != '0);
      status.aux_nz      = (aux_ptr_ff != '0);
      status.pipe_busy   = (tag_ff != TAG_NONE);
      status.sort_needed = (largest_ff != '0);
      status.last_pass   = ((bit_ff + BW'(1)) == nbits_ff);
   end

   // Result word straight from the registered read of the deque.
   assign rsp_strobe            = (tag_ff == TAG_EMIT);
   assign rsp_word.sorted_value = deque_q;
   assign rsp_word.last_out     = emit_last_ff;
   assign rsp_word.overflow     = dropped_ff;

   // The stack never holds more keys than the deque owns.
   a_aux_bound: assert property (@(posedge clock) disable iff (reset)
      aux_ptr_ff <= count_ff)
      else $error("auxiliary stack deeper than the key count");

   // The work counter never runs past the key count.
   a_left_bound: assert property (@(posedge clock) disable iff (reset)
      left_ff <= count_ff)
      else $error("work counter exceeds the key count");

   // The final result word closes the emit sweep.
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && emit_last_ff) |-> (left_ff == '0))
      else $error("last word shown with keys still to emit");

   // A clear leaves an empty set with no overflow.
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (count_ff == '0) && (aux_ptr_ff == '0) && !dropped_ff)
      else $error("set not empty after clear");

endmodule

`default_nettype wire

/* rtl/binary_radix_sort_two_stacks_unit.sv */
`default_nettype none

// Binary radix sort unit, least significant bit first.
// Input: a key word is taken at a rising edge where start is high and busy
// is low. Keys are loaded one per cycle into a deque of MAX_ITEMS slots;
// keys beyond that are dropped and flagged in every result word of the set.
// A word with last_item set closes the set; busy then rises until the
// sorted keys have all been sent.
// Sort: a setup step, then one pass per significant bit of the largest
// key (at most ten). A pass reads every key once from the deque RAM, one
// per cycle, sending set bits to the back and clear bits to a stack RAM,
// then pops the stack back to the front, one per cycle.
// Output: one result word per kept key, back to back on rsp_strobe,
// one cycle each, the final one marked by last_out. The receiver cannot
// stall; every strobed word counts as taken. Busy falls as the pointers
// are cleared after the final word, and then a new set may begin.
// Reset clears all pointers and flags at once and the unit is ready in the
// next cycle; the RAM contents are not cleared.
module binary_radix_sort_two_stacks_unit #(
   parameter int MAX_ITEMS = brsts_pkg::MAX_ITEMS_DEFAULT,
   parameter int KEY_BITS  = brsts_pkg::KEY_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire brsts_pkg::req_word_type req_word,
   output logic                        rsp_strobe,
   output brsts_pkg::rsp_word_type     rsp_word
);

   brsts_pkg::cmd_type    cmd;
   brsts_pkg::status_type status;

   // Sequencer for load, passes and emit.
   brsts_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_last (req_word.last_item),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // Pointers, counters and the two RAMs.
   brsts_dpath #(
      .MAX_ITEMS (MAX_ITEMS),
      .KEY_BITS  (KEY_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .key_value  (req_word.key_value),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

`default_nettype wire

/* tb/binary_radix_sort_two_stacks_unit_tb.sv */
module binary_radix_sort_two_stacks_unit_tb;
   import brsts_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int MAX_KEYS = MAX_ITEMS_DEFAULT;
   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int SETTLE_CYCLES = 24;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   req_word_type req_word;
   logic rsp_strobe;
   rsp_word_type rsp_word;

   // Keys of the set being loaded, sorted words still due, and run status.
   logic [KEY_W-1:0] loaded_keys[$];
   logic keys_dropped;
   rsp_word_type sorted_due[$];
   rsp_word_type due_word;
   int error_count;
   int sender_idle_pct;
   int keys_sent;

   binary_radix_sort_two_stacks_unit #(
      .MAX_ITEMS(MAX_ITEMS_DEFAULT),
      .KEY_BITS(KEY_BITS_DEFAULT)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_word(req_word),
      .rsp_strobe(rsp_strobe),
      .rsp_word(rsp_word)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Store one accepted key; on the closing key, sort the set by binary LSD
   // radix and queue the words that the unit should send back.
   function automatic void load_key(input req_word_type w);
      logic [KEY_W-1:0] order[$];
      logic [KEY_W-1:0] zeros[$];
      logic [KEY_W-1:0] ones[$];
      logic [KEY_W-1:0] top_key;
      int bit_len;
      rsp_word_type r;
      if (loaded_keys.size() < MAX_KEYS) begin
         loaded_keys.push_back(w.key_value);
      end else begin
         keys_dropped = 1'b1;
      end
      if (!w.last_item) begin
         return;
      end
      top_key = '0;
      foreach (loaded_keys[i]) begin
         if (loaded_keys[i] > top_key) begin
            top_key = loaded_keys[i];
         end
      end
      // One pass per significant bit of the largest key.
      bit_len = 0;
      for (int i = 0; i < KEY_W; i++) begin
         if (top_key[i]) begin
            bit_len = i + 1;
         end
      end
      foreach (loaded_keys[i]) begin
         order.push_back(loaded_keys[i]);
      end
      for (int b = 0; b < bit_len; b++) begin
         zeros.delete();
         ones.delete();
         foreach (order[i]) begin
            if (order[i][b]) begin
               ones.push_back(order[i]);
            end else begin
               zeros.push_back(order[i]);
            end
         end
         order.delete();
         foreach (zeros[i]) begin
            order.push_back(zeros[i]);
         end
         foreach (ones[i]) begin
            order.push_back(ones[i]);
         end
      end
      foreach (order[i]) begin
         r.sorted_value = order[i];
         r.last_out = (i == order.size() - 1);
         r.overflow = keys_dropped;
         sorted_due.push_back(r);
      end
      loaded_keys.delete();
      keys_dropped = 1'b0;
   endfunction

   // Offer one key word, after idle cycles at the current rate, and hold it
   // until taken.
   task automatic send_key(input logic [KEY_W-1:0] key, input logic is_last);
      req_word_type w;
      w.key_value = key;
      w.last_item = is_last;
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      load_key(w);
      keys_sent++;
   endtask

   // A whole set of random keys limited to bit_len bits; the final key closes it.
   task automatic send_set(input int count, input int bit_len);
      logic [KEY_W-1:0] key;
      for (int i = 0; i < count; i++) begin
         key = (bit_len == 0) ? '0 : KEY_W'($urandom_range((1 << bit_len) - 1, 0));
         send_key(key, i == count - 1);
      end
   endtask

   // Stop offering words until every sorted word due has come back.
   task automatic wait_drained();
      start <= 1'b0;
      while (sorted_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Every strobed word is compared with the oldest sorted word due.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (sorted_due.size() == 0) begin
            error_count++;
            $display("%0t: unexpected word, expected none, actual value %0d last %0b ovf %0b",
                     $time, rsp_word.sorted_value, rsp_word.last_out, rsp_word.overflow);
         end else begin
            due_word = sorted_due.pop_front();
            check_field("sorted_value", due_word.sorted_value, rsp_word.sorted_value);
            check_field("last_out", due_word.last_out, rsp_word.last_out);
            check_field("overflow", due_word.overflow, rsp_word.overflow);
         end
      end
   end

   // Single keys at both extremes, an all-zero set kept in load order,
   // duplicates, and keys that exercise every bit.
   task automatic test_directed();
      send_key(10'd0, 1'b1);
      send_key(10'd1023, 1'b1);
      send_key(10'd0, 1'b0);
      send_key(10'd0, 1'b0);
      send_key(10'd0, 1'b1);
      send_key(10'd1023, 1'b0);
      send_key(10'd0, 1'b0);
      send_key(10'd512, 1'b0);
      send_key(10'd1, 1'b0);
      send_key(10'd1023, 1'b0);
      send_key(10'd341, 1'b0);
      send_key(10'd682, 1'b1);
      send_key(10'd5, 1'b0);
      send_key(10'd3, 1'b0);
      send_key(10'd5, 1'b0);
      send_key(10'd1, 1'b1);
      wait_drained();
   endtask

   // A set that fills the deque exactly, then one whose extra keys are
   // dropped, the closing key among them.
   task automatic test_capacity();
      send_set(MAX_KEYS, KEY_W);
      send_set(MAX_KEYS + 2, $urandom_range(KEY_W, 1));
      wait_drained();
   endtask

   // Random sets, mostly small, some near or past capacity, at one idle rate.
   task automatic test_random_sets(input int idle_pct, input int item_goal);
      int first_count;
      int size_pick;
      int set_size;
      int bit_len;
      sender_idle_pct = idle_pct;
      first_count = keys_sent;
      while (keys_sent - first_count < item_goal) begin
         size_pick = $urandom_range(99);
         if (size_pick < 6) begin
            set_size = $urandom_range(MAX_KEYS + 4, MAX_KEYS + 1);
         end else if (size_pick < 14) begin
            set_size = $urandom_range(MAX_KEYS, 40);
         end else begin
            set_size = $urandom_range(12, 1);
         end
         if ($urandom_range(7) == 0) begin
            bit_len = 0;
         end else if ($urandom_range(1) == 0) begin
            bit_len = KEY_W;
         end else begin
            bit_len = $urandom_range(KEY_W, 1);
         end
         send_set(set_size, bit_len);
         // Now and then hold off until the unit has sent everything back.
         if ($urandom_range(5) == 0) begin
            wait_drained();
         end
      end
      wait_drained();
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_word <= '0;
      error_count = 0;
      keys_sent = 0;
      keys_dropped = 1'b0;
      sender_idle_pct = 12;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_capacity();
      test_random_sets(12, 100);
      test_random_sets(48, 100);
      test_random_sets(0, 100);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && sorted_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Hard stop in case the unit hangs.
   initial begin
      #(CLOCK_PERIOD * LIMIT_CYCLES);
      $display("%0t: timeout with %0d words still due", $time, sorted_due.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
